// ----- hw/rtl/wav_pcm_to_mono8_parser_defines.svh -----
// Assertion macros shared by the WAVE parser RTL.
`ifndef WAV_PCM_TO_MONO8_PARSER_DEFINES_SVH
`define WAV_PCM_TO_MONO8_PARSER_DEFINES_SVH
`ifndef SYNTH
`define WAVP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define WAVP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WAVP_ASSERT(lbl, clk, rst, prop, msg)
`define WAVP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- hw/rtl/wavp_pkg.sv -----
// Types, codes and helpers shared by the WAVE parser modules.
package wavp_pkg;

   localparam logic [31:0] RIFF_PREAMBLE_LEN  = 32'd12;
   localparam logic [31:0] CHUNK_PREAMBLE_LEN = 32'd8;
   localparam logic [31:0] FMT_MIN_LEN        = 32'd16;
   localparam logic [15:0] PCM                = 16'd1;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [2:0] PH_HEADER = 3'd0;
   localparam logic [2:0] PH_CHUNK  = 3'd1;
   localparam logic [2:0] PH_BODY   = 3'd2;
   localparam logic [2:0] PH_PAD    = 3'd3;
   localparam logic [2:0] PH_HALT   = 3'd4;

   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_FMT   = 2'd1;
   localparam logic [1:0] KIND_SKIP  = 2'd2;
   localparam logic [1:0] KIND_CONV  = 2'd3;

   localparam logic [2:0] STATUS_OK          = 3'd0;
   localparam logic [2:0] STATUS_NOT_WAVE    = 3'd1;
   localparam logic [2:0] STATUS_SHORT_FMT   = 3'd2;
   localparam logic [2:0] STATUS_MISSING     = 3'd3;
   localparam logic [2:0] STATUS_UNSUPPORTED = 3'd4;

   localparam int RSP_DATA_WIDTH = 48;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       end_of_file;
   } wavp_word_type;

   typedef struct packed {
      logic        sample_valid;
      logic [7:0]  mono_sample;
      logic        done_res;
      logic [2:0]  status;
      logic [31:0] sample_rate;
   } wavp_result_type;

   function automatic logic wavp_format_ok(input logic seen, input logic [15:0] tag,
                                           input logic [15:0] chan, input logic [15:0] bits,
                                           input logic [31:0] rate);
      logic ok;
      ok = seen && (tag == PCM) && (chan inside {16'd1, 16'd2}) &&
           (bits inside {16'd8, 16'd16}) && (rate != 32'd0);
      return ok;
   endfunction

endpackage

// ----- hw/rtl/wavp_in_reg.sv -----
// Input register that holds one file byte word until the parser takes it.
module wavp_in_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  wavp_pkg::wavp_word_type in_word,
   output logic                   word_valid,
   output wavp_pkg::wavp_word_type word,
   input  logic                   take
);
   import wavp_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   wavp_word_type word_ff;

   assign in_ready   = !valid_ff || take;
   assign word_valid = valid_ff;
   assign word       = word_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         word_ff <= in_word;
      end
   end

endmodule

// ----- hw/rtl/wavp_core.sv -----
// Parser state and the per-byte chunk walk, format latch and downmix.
`include "wav_pcm_to_mono8_parser_defines.svh"
module wavp_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     word_valid,
   input  wavp_pkg::wavp_word_type  word,
   output logic                     take,
   input  logic                     out_space,
   output logic                     has_result,
   output wavp_pkg::wavp_result_type result
);
   import wavp_pkg::*;

   logic [2:0]         phase_ff, phase_in;
   logic [31:0]        count_ff, count_in;
   logic [31:0]        tag_ff, tag_in;
   logic [31:0]        length_ff, length_in;
   logic [15:0]        fmt_tag_ff, fmt_tag_in;
   logic [15:0]        fmt_chan_ff, fmt_chan_in;
   logic [31:0]        fmt_rate_ff, fmt_rate_in;
   logic [15:0]        fmt_bits_ff, fmt_bits_in;
   logic               fmt_seen_ff, fmt_seen_in;
   logic               data_seen_ff, data_seen_in;
   logic [7:0]         low_hold_ff, low_hold_in;
   logic signed [17:0] sum_ff, sum_in;
   logic [1:0]         frame_idx_ff, frame_idx_in;
   logic [2:0]         error_ff, error_in;
   logic [1:0]         kind_ff, kind_in;

   logic               emit;
   logic signed [17:0] addend;
   logic signed [17:0] quot;
   logic [1:0]         idx_next;
   logic [1:0]         frame_bytes;
   logic [31:0]        count_next;
   logic [2:0]         status_code;
   logic               clear;

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      tag_in       = {word.file_byte, tag_ff[31:8]};
      length_in    = length_ff;
      fmt_tag_in   = fmt_tag_ff;
      fmt_chan_in  = fmt_chan_ff;
      fmt_rate_in  = fmt_rate_ff;
      fmt_bits_in  = fmt_bits_ff;
      fmt_seen_in  = fmt_seen_ff;
      data_seen_in = data_seen_ff;
      low_hold_in  = low_hold_ff;
      sum_in       = sum_ff;
      frame_idx_in = frame_idx_ff;
      error_in     = error_ff;
      kind_in      = kind_ff;
      emit         = 1'b0;
      addend       = '0;
      quot         = '0;
      idx_next     = frame_idx_ff + 2'd1;
      frame_bytes  = '0;
      count_next   = count_ff + 32'd1;

      case (phase_ff)
         PH_HEADER: begin
            if ((count_ff == 32'd3 && tag_in != TAG_RIFF) ||
                (count_ff == 32'd11 && tag_in != TAG_WAVE)) begin
               error_in = STATUS_NOT_WAVE;
               phase_in = PH_HALT;
            end else if (count_ff == RIFF_PREAMBLE_LEN - 32'd1) begin
               phase_in = PH_CHUNK;
               count_in = '0;
            end else begin
               count_in = count_next;
            end
         end
         PH_CHUNK: begin
            if (count_ff == 32'd3) begin
               if (tag_in == TAG_FMT) begin
                  kind_in = KIND_FMT;
               end else if (tag_in == TAG_DATA) begin
                  kind_in = wavp_format_ok(fmt_seen_ff, fmt_tag_ff, fmt_chan_ff,
                                           fmt_bits_ff, fmt_rate_ff) ? KIND_CONV : KIND_SKIP;
               end else begin
                  kind_in = KIND_OTHER;
               end
            end
            if (count_ff < CHUNK_PREAMBLE_LEN - 32'd1) begin
               count_in = count_next;
            end else begin
               length_in    = tag_in;
               count_in     = '0;
               sum_in       = '0;
               frame_idx_in = '0;
               if (kind_in == KIND_SKIP || kind_in == KIND_CONV) begin
                  data_seen_in = 1'b1;
               end
               if (kind_in == KIND_FMT && tag_in < FMT_MIN_LEN) begin
                  error_in = STATUS_SHORT_FMT;
                  phase_in = PH_HALT;
               end else begin
                  phase_in = (tag_in == 32'd0) ? PH_CHUNK : PH_BODY;
               end
            end
         end
         PH_BODY: begin
            if (kind_ff == KIND_FMT) begin
               if (count_ff == 32'd1) begin
                  fmt_tag_in = tag_in[31:16];
               end else if (count_ff == 32'd3) begin
                  fmt_chan_in = tag_in[31:16];
               end else if (count_ff == 32'd7) begin
                  fmt_rate_in = tag_in;
               end else if (count_ff == 32'd15) begin
                  fmt_bits_in = tag_in[31:16];
                  fmt_seen_in = 1'b1;
               end
            end else if (kind_ff == KIND_CONV) begin
               if (fmt_bits_ff == 16'd8) begin
                  // Flipping the top bit recenters an unsigned byte around zero.
                  addend      = 18'(signed'({~word.file_byte[7], word.file_byte[6:0], 8'h00}));
                  sum_in      = sum_ff + addend;
                  frame_bytes = fmt_chan_ff[1:0];
               end else begin
                  if (!frame_idx_ff[0]) begin
                     low_hold_in = word.file_byte;
                  end else begin
                     addend = 18'(signed'({word.file_byte, low_hold_ff}));
                     sum_in = sum_ff + addend;
                  end
                  frame_bytes = {fmt_chan_ff[0], 1'b0};
               end
               if (idx_next == frame_bytes) begin
                  // Halving truncates toward zero, then the shift by eight floors.
                  if (fmt_chan_ff == 16'd2) begin
                     quot = (sum_in + $signed({17'd0, sum_in[17]})) >>> 1;
                  end else begin
                     quot = sum_in;
                  end
                  emit         = 1'b1;
                  sum_in       = '0;
                  frame_idx_in = '0;
               end else begin
                  frame_idx_in = idx_next;
               end
            end
            if (count_next == length_ff) begin
               phase_in = length_ff[0] ? PH_PAD : PH_CHUNK;
               count_in = '0;
            end else begin
               count_in = count_next;
            end
         end
         PH_PAD: begin
            phase_in = PH_CHUNK;
            count_in = '0;
         end
         default: begin
         end
      endcase

      if (error_in != STATUS_OK) begin
         status_code = error_in;
      end else if (phase_in == PH_HEADER) begin
         status_code = STATUS_NOT_WAVE;
      end else if (phase_in == PH_BODY && kind_in == KIND_FMT && count_in < FMT_MIN_LEN) begin
         status_code = STATUS_SHORT_FMT;
      end else if (!fmt_seen_in || !data_seen_in) begin
         status_code = STATUS_MISSING;
      end else if (!wavp_format_ok(fmt_seen_in, fmt_tag_in, fmt_chan_in, fmt_bits_in,
                                   fmt_rate_in)) begin
         status_code = STATUS_UNSUPPORTED;
      end else begin
         status_code = STATUS_OK;
      end
   end

   always_comb begin
      result.sample_valid = emit;
      result.mono_sample  = emit ? quot[15:8] : 8'h00;
      result.done_res     = word.end_of_file;
      result.status       = word.end_of_file ? status_code : STATUS_OK;
      result.sample_rate  = (word.end_of_file && status_code == STATUS_OK) ? fmt_rate_in
                                                                           : 32'd0;
   end

   assign has_result = emit || word.end_of_file;
   assign take       = word_valid && (!has_result || out_space);
   assign clear      = reset || (take && word.end_of_file);

   always_ff @(posedge clock) begin
      if (clear) begin
         phase_ff     <= PH_HEADER;
         count_ff     <= '0;
         tag_ff       <= '0;
         length_ff    <= '0;
         fmt_tag_ff   <= '0;
         fmt_chan_ff  <= '0;
         fmt_rate_ff  <= '0;
         fmt_bits_ff  <= '0;
         fmt_seen_ff  <= 1'b0;
         data_seen_ff <= 1'b0;
         low_hold_ff  <= '0;
         sum_ff       <= '0;
         frame_idx_ff <= '0;
         error_ff     <= STATUS_OK;
         kind_ff      <= KIND_OTHER;
      end else if (take) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         tag_ff       <= tag_in;
         length_ff    <= length_in;
         fmt_tag_ff   <= fmt_tag_in;
         fmt_chan_ff  <= fmt_chan_in;
         fmt_rate_ff  <= fmt_rate_in;
         fmt_bits_ff  <= fmt_bits_in;
         fmt_seen_ff  <= fmt_seen_in;
         data_seen_ff <= data_seen_in;
         low_hold_ff  <= low_hold_in;
         sum_ff       <= sum_in;
         frame_idx_ff <= frame_idx_in;
         error_ff     <= error_in;
         kind_ff      <= kind_in;
      end
   end

   `WAVP_ASSERT(a_sample_only_in_data, clock, reset,
      result.sample_valid |-> (phase_ff == PH_BODY && kind_ff == KIND_CONV),
      "sample outside a converted data chunk")
   `WAVP_ASSERT(a_status_with_done, clock, reset,
      (result.status != STATUS_OK) |-> result.done_res,
      "status set on a word that is not the final one")
   `WAVP_ASSERT(a_restart_after_eof, clock, reset,
      (take && word.end_of_file) |=>
         (phase_ff == PH_HEADER && count_ff == 32'd0 && !fmt_seen_ff && !data_seen_ff),
      "parser did not restart after the final byte")
   `WAVP_ASSERT(a_conv_channels, clock, reset,
      (phase_ff == PH_BODY && kind_ff == KIND_CONV) |->
         (fmt_chan_ff == 16'd1 || fmt_chan_ff == 16'd2),
      "converting with an unsupported channel count")

endmodule

// ----- hw/rtl/wavp_out_reg.sv -----
// Result register that holds one result word until the consumer takes it.
module wavp_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  wavp_pkg::wavp_result_type result,
   output logic                      out_space,
   output logic                      out_valid,
   input  logic                      out_ready,
   output wavp_pkg::wavp_result_type out_result
);
   import wavp_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   wavp_result_type result_ff;

   assign out_space  = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

endmodule

// ----- hw/rtl/wav_pcm_to_mono8_parser.sv -----
// Top level of the streaming WAVE parser with downmix to signed 8-bit mono.
//
//   channel   direction   fields
//   req       in          tdata: file_byte; tlast: end_of_file
//   rsp       out         tdata: mono_sample, status, sample_rate; tlast: done_res;
//                         tuser: sample_valid
//
// One byte word is taken per cycle; its result, if any, is offered on rsp once the word has
// passed the input register, then the parse and downmix logic into the result register.
// Bytes that produce no result keep flowing even while a result word waits.
// A stalled result holds back the next byte that produces a result and every byte behind it.
// Reset clears the parser to the start of a file; after the final byte the parser returns
// to that state on its own.
module wav_pcm_to_mono8_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] file_byte
   input  logic                               req_tlast,   // end_of_file
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [7:0] mono_sample, [10:8] status, [42:11] sample_rate, [47:43] zero
   output logic [wavp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic                               rsp_tlast,   // done_res
   output logic                               rsp_tuser    // sample_valid
);
   import wavp_pkg::*;

   wavp_word_type   in_word;
   wavp_word_type   word;
   logic            word_valid;
   logic            take;
   logic            out_space;
   logic            has_result;
   wavp_result_type result;
   wavp_result_type out_result;

   assign in_word.file_byte   = req_tdata;
   assign in_word.end_of_file = req_tlast;

   wavp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_word    (in_word),
      .word_valid (word_valid),
      .word       (word),
      .take       (take)
   );

   wavp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .word_valid (word_valid),
      .word       (word),
      .take       (take),
      .out_space  (out_space),
      .has_result (has_result),
      .result     (result)
   );

   wavp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (take && has_result),
      .result     (result),
      .out_space  (out_space),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (out_result)
   );

   assign rsp_tdata = {5'b00000, out_result.sample_rate, out_result.status,
                       out_result.mono_sample};
   assign rsp_tlast = out_result.done_res;
   assign rsp_tuser = out_result.sample_valid;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the WAVE parser: WAVE files of many shapes in, mono words checked.
import wavp_pkg::*;

typedef struct packed {
   logic        valid;
   logic [7:0]  pcm;
   logic        done;
   logic [2:0]  status;
   logic [31:0] rate;
} mono8_word_type;

class wave_parse_checker;
   localparam int PCM_OFFSET = 128;

   logic [2:0]  phase;
   logic [31:0] count;
   logic [31:0] window;
   logic [31:0] chunk_len;
   logic [15:0] fmt_tag;
   logic [15:0] fmt_chan;
   logic [15:0] fmt_bits;
   logic [31:0] fmt_rate;
   bit          fmt_seen;
   bit          data_seen;
   logic [7:0]  low_hold;
   int          frame_sum;
   logic [1:0]  frame_idx;
   logic [2:0]  err_code;
   logic [1:0]  kind;

   mono8_word_type awaited[$];
   int             fail_count;

   function new();
      fail_count = 0;
      clear_parse();
   endfunction

   function void clear_parse();
      phase = PH_HEADER;
      count = '0;
      window = '0;
      chunk_len = '0;
      fmt_tag = '0;
      fmt_chan = '0;
      fmt_bits = '0;
      fmt_rate = '0;
      fmt_seen = 1'b0;
      data_seen = 1'b0;
      low_hold = '0;
      frame_sum = 0;
      frame_idx = '0;
      err_code = STATUS_OK;
      kind = KIND_OTHER;
   endfunction

   function bit format_usable();
      return fmt_seen && fmt_tag == PCM && (fmt_chan == 16'd1 || fmt_chan == 16'd2) &&
             (fmt_bits == 16'd8 || fmt_bits == 16'd16) && fmt_rate != 32'd0;
   endfunction

   // Advances the parser by one accepted byte and queues the word it must produce.
   function void note_byte(logic [7:0] b, logic last);
      bit             emit;
      int             smp;
      int             v;
      logic [31:0]    pos;
      logic [1:0]     frame_bytes;
      logic [2:0]     st;
      mono8_word_type w;
      emit = 1'b0;
      smp = 0;
      pos = count;
      window = {b, window[31:8]};
      case (phase)
         PH_HEADER: begin
            if ((pos == 32'd3 && window != TAG_RIFF) || (pos == 32'd11 && window != TAG_WAVE)) begin
               err_code = STATUS_NOT_WAVE;
               phase = PH_HALT;
            end else if (pos + 32'd1 == RIFF_PREAMBLE_LEN) begin
               phase = PH_CHUNK;
               count = '0;
            end else begin
               count = pos + 32'd1;
            end
         end
         PH_CHUNK: begin
            if (pos == 32'd3) begin
               if (window == TAG_FMT)
                  kind = KIND_FMT;
               else if (window == TAG_DATA)
                  kind = format_usable() ? KIND_CONV : KIND_SKIP;
               else
                  kind = KIND_OTHER;
            end
            if (pos + 32'd1 < CHUNK_PREAMBLE_LEN) begin
               count = pos + 32'd1;
            end else begin
               chunk_len = window;
               count = '0;
               frame_sum = 0;
               frame_idx = '0;
               if (kind == KIND_SKIP || kind == KIND_CONV)
                  data_seen = 1'b1;
               if (kind == KIND_FMT && chunk_len < FMT_MIN_LEN) begin
                  err_code = STATUS_SHORT_FMT;
                  phase = PH_HALT;
               end else begin
                  phase = (chunk_len == 32'd0) ? PH_CHUNK : PH_BODY;
               end
            end
         end
         PH_BODY: begin
            if (kind == KIND_FMT) begin
               if (pos == 32'd1)
                  fmt_tag = window[31:16];
               else if (pos == 32'd3)
                  fmt_chan = window[31:16];
               else if (pos == 32'd7)
                  fmt_rate = window;
               else if (pos == 32'd15) begin
                  fmt_bits = window[31:16];
                  fmt_seen = 1'b1;
               end
            end else if (kind == KIND_CONV) begin
               if (fmt_bits == 16'd8) begin
                  frame_sum += (int'(b) - PCM_OFFSET) * 256;
                  frame_bytes = fmt_chan[1:0];
               end else begin
                  if (!frame_idx[0]) begin
                     low_hold = b;
                  end else begin
                     v = int'($signed({b, low_hold}));
                     frame_sum += v;
                  end
                  frame_bytes = {fmt_chan[0], 1'b0};
               end
               frame_idx = frame_idx + 2'd1;
               if (frame_idx == frame_bytes) begin
                  smp = (frame_sum / int'(fmt_chan)) >>> 8;
                  emit = 1'b1;
                  frame_sum = 0;
                  frame_idx = '0;
               end
            end
            count = pos + 32'd1;
            if (count == chunk_len) begin
               phase = chunk_len[0] ? PH_PAD : PH_CHUNK;
               count = '0;
            end
         end
         PH_PAD: begin
            phase = PH_CHUNK;
            count = '0;
         end
         default: ;
      endcase

      w.valid = emit;
      w.pcm = emit ? smp[7:0] : 8'd0;
      w.done = 1'b0;
      w.status = STATUS_OK;
      w.rate = '0;
      if (last) begin
         if (err_code != STATUS_OK)
            st = err_code;
         else if (phase == PH_HEADER)
            st = STATUS_NOT_WAVE;
         else if (phase == PH_BODY && kind == KIND_FMT && count < FMT_MIN_LEN)
            st = STATUS_SHORT_FMT;
         else if (!fmt_seen || !data_seen)
            st = STATUS_MISSING;
         else if (!format_usable())
            st = STATUS_UNSUPPORTED;
         else
            st = STATUS_OK;
         w.done = 1'b1;
         w.status = st;
         w.rate = (st == STATUS_OK) ? fmt_rate : 32'd0;
         clear_parse();
      end
      if (emit || last)
         awaited = {awaited, w};
   endfunction

   function void compare_field(string label, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      end
   endfunction

   function void check_word(logic [47:0] data, logic last, logic user);
      mono8_word_type w;
      if (awaited.size() == 0) begin
         fail_count++;
         $display("%0t: unexpected result word, actual data %h last %b user %b",
                  $time, data, last, user);
         return;
      end
      w = awaited.pop_front();
      compare_field("sample_valid", 32'(w.valid), 32'(user));
      compare_field("mono_sample", 32'(w.pcm), 32'(data[7:0]));
      compare_field("done_res", 32'(w.done), 32'(last));
      compare_field("status", 32'(w.status), 32'(data[10:8]));
      compare_field("sample_rate", w.rate, data[42:11]);
      compare_field("padding", 32'd0, 32'(data[47:43]));
   endfunction
endclass

module testbench;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_LIMIT    = 5000;
   localparam int LONG_HOLD      = 400;
   localparam int TARGET_BYTES   = 1150;
   localparam int NUM_SHAPES     = 12;

   typedef enum int {
      FILE_GOOD, FILE_RICH, FILE_DATA_FIRST, FILE_NO_FMT, FILE_NO_DATA, FILE_UNSUPPORTED,
      FILE_SHORT_FMT, FILE_FMT_CUT, FILE_CUT, FILE_BAD_RIFF, FILE_BAD_WAVE, FILE_NOISE
   } file_shape_type;

   typedef enum int {READY_FULL, READY_THIRDS, READY_MOSTLY, READY_SPARSE} ready_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   logic        hold_request = 1'b0;
   bit          hold_file = 1'b0;
   logic [7:0]  file_bytes[$];
   int          fmt_body_at;
   int          burst_left = 0;
   int          bytes_sent = 0;
   int          quiet_cycles = 0;

   wave_parse_checker board = new();

   always #6 clock = ~clock;

   wav_pcm_to_mono8_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            board.check_word(rsp_tdata, rsp_tlast, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // The receiver switches among readiness patterns at random and honors one long hold.
   initial begin
      ready_mode_type ready_mode;
      int             ready_left;
      int             ready_tick;
      ready_mode = READY_FULL;
      ready_left = 0;
      ready_tick = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_request <= 1'b0;
         end
         if (ready_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            ready_left = $urandom_range(20, 100);
         end
         ready_left--;
         ready_tick++;
         case (ready_mode)
            READY_FULL:   rsp_tready <= 1'b1;
            READY_THIRDS: rsp_tready <= (ready_tick % 3) != 0;
            READY_MOSTLY: rsp_tready <= $urandom_range(0, 3) != 0;
            default:      rsp_tready <= $urandom_range(0, 3) == 0;
         endcase
      end
   end

   function void put_byte(logic [7:0] b);
      file_bytes = {file_bytes, b};
   endfunction

   function void put_le16(logic [15:0] v);
      put_byte(v[7:0]);
      put_byte(v[15:8]);
   endfunction

   function void put_le32(logic [31:0] v);
      put_le16(v[15:0]);
      put_le16(v[31:16]);
   endfunction

   function logic [7:0] data_byte();
      logic [7:0] picks[4];
      picks = '{8'h00, 8'hFF, 8'h80, 8'h7F};
      if ($urandom_range(0, 7) == 0)
         return picks[$urandom_range(0, 3)];
      return 8'($urandom_range(0, 255));
   endfunction

   function void put_other_chunk();
      logic [31:0] id;
      int          len;
      id = $urandom();
      if (id == TAG_FMT || id == TAG_DATA)
         id ^= 32'd1;
      len = $urandom_range(0, 9);
      put_le32(id);
      put_le32(32'(len));
      repeat (len) put_byte(8'($urandom_range(0, 255)));
      if (len % 2 == 1)
         put_byte(8'($urandom_range(0, 255)));
   endfunction

   function void put_data_chunk();
      int len;
      len = hold_file ? 90 : $urandom_range(0, 24);
      put_le32(TAG_DATA);
      put_le32(32'(len));
      repeat (len) put_byte(data_byte());
      if (len % 2 == 1)
         put_byte(8'($urandom_range(0, 255)));
   endfunction

   function void put_fmt_chunk(bit broken);
      int          len;
      logic [15:0] tag;
      logic [15:0] chan;
      logic [15:0] width_bits;
      logic [31:0] rate;
      len = 16 + $urandom_range(0, 3);
      tag = PCM;
      chan = 16'($urandom_range(1, 2));
      width_bits = $urandom_range(0, 1) ? 16'd8 : 16'd16;
      case ($urandom_range(0, 5))
         0:       rate = 32'd1;
         1:       rate = 32'hFFFF_FFFF;
         default: rate = $urandom() | 32'd1;
      endcase
      if (hold_file) begin
         chan = 16'd1;
         width_bits = 16'd8;
      end
      if (broken) begin
         case ($urandom_range(0, 3))
            0:       tag = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(2, 65535));
            1:       chan = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(3, 65535));
            2:       width_bits = $urandom_range(0, 1) ? 16'd24 : 16'($urandom_range(0, 7));
            default: rate = 32'd0;
         endcase
      end
      put_le32(TAG_FMT);
      put_le32(32'(len));
      fmt_body_at = file_bytes.size();
      put_le16(tag);
      put_le16(chan);
      put_le32(rate);
      put_le32($urandom());
      put_le16(16'($urandom_range(0, 65535)));
      put_le16(width_bits);
      repeat (len - 16) put_byte(8'($urandom_range(0, 255)));
      if (len % 2 == 1)
         put_byte(8'($urandom_range(0, 255)));
   endfunction

   function void build_file(file_shape_type shape);
      int len;
      int keep;
      file_bytes.delete();
      put_le32(shape == FILE_BAD_RIFF ? TAG_RIFF ^ (32'd1 << $urandom_range(0, 31)) : TAG_RIFF);
      put_le32($urandom());
      put_le32(shape == FILE_BAD_WAVE ? TAG_WAVE ^ (32'd1 << $urandom_range(0, 31)) : TAG_WAVE);
      if (shape == FILE_NOISE) begin
         repeat ($urandom_range(8, 40)) put_byte(8'($urandom_range(0, 255)));
      end else begin
         if (shape == FILE_RICH || $urandom_range(0, 3) == 0)
            put_other_chunk();
         if (shape == FILE_DATA_FIRST)
            put_data_chunk();
         if (shape == FILE_SHORT_FMT) begin
            len = $urandom_range(0, 15);
            put_le32(TAG_FMT);
            put_le32(32'(len));
            repeat (len) put_byte(8'($urandom_range(0, 255)));
         end else if (shape != FILE_NO_FMT) begin
            put_fmt_chunk(shape == FILE_UNSUPPORTED);
         end
         if (shape == FILE_RICH) begin
            // A second format replaces the first one between two data chunks.
            put_data_chunk();
            put_other_chunk();
            put_fmt_chunk(1'b0);
         end
         if (shape != FILE_NO_DATA)
            repeat ($urandom_range(1, shape == FILE_RICH ? 2 : 1)) put_data_chunk();
      end
      if (shape == FILE_FMT_CUT) begin
         keep = fmt_body_at + $urandom_range(1, 15);
         while (file_bytes.size() > keep) void'(file_bytes.pop_back());
      end else if (shape == FILE_CUT) begin
         keep = $urandom_range(1, file_bytes.size());
         while (file_bytes.size() > keep) void'(file_bytes.pop_back());
      end
   endfunction

   // The sender works in bursts; end_of_file rides on the last word of the file.
   task automatic send_file();
      for (int i = 0; i < file_bytes.size(); i++) begin
         if (burst_left == 0) begin
            if ($urandom_range(0, 2) == 0) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
         end
         req_tdata <= file_bytes[i];
         req_tlast <= (i == file_bytes.size() - 1);
         req_tvalid <= 1'b1;
         do @(posedge clock); while (!req_tready);
         burst_left--;
         bytes_sent++;
      end
   endtask

   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (board.awaited.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin
      file_shape_type shape;
      int             file_idx;
      int             wait_cycles;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Short files: lone bytes, a wrong first tag, a cut header and a bare header.
      file_bytes = '{8'h00};
      send_file();
      file_bytes = '{8'hFF};
      send_file();
      file_bytes.delete();
      put_le32({8'h58, TAG_RIFF[23:0]});
      send_file();
      file_bytes.delete();
      put_le32(TAG_RIFF);
      put_le16(16'h0000);
      send_file();
      file_bytes.delete();
      put_le32(TAG_RIFF);
      put_le32(32'hFFFF_FFFF);
      put_le32(TAG_WAVE);
      send_file();

      file_idx = 0;
      while (bytes_sent < TARGET_BYTES) begin
         if (file_idx < NUM_SHAPES)
            shape = file_shape_type'(file_idx);
         else if ($urandom_range(0, 9) < 6)
            shape = $urandom_range(0, 1) ? FILE_GOOD : FILE_RICH;
         else
            shape = file_shape_type'($urandom_range(0, NUM_SHAPES - 1));
         hold_file = (file_idx == NUM_SHAPES + 1);
         if (hold_file) begin
            shape = FILE_GOOD;
            hold_request <= 1'b1;
         end
         build_file(shape);
         send_file();
         if (file_idx == 3 || $urandom_range(0, 5) == 0)
            wait_all_results();
         file_idx++;
      end

      req_tvalid <= 1'b0;
      wait_cycles = 0;
      @(negedge clock);
      while (board.awaited.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (8) @(posedge clock);
      if (board.awaited.size() != 0) begin
         board.fail_count++;
         $display("%0t: %0d result words never arrived", $time, board.awaited.size());
      end
      if (board.fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
